// File: design/rbd_pkg.sv
// Shared types and constants for the RGBA 2x2 box downscaler.
package rbd_pkg;

    localparam int CH_W         = 8;
    localparam int SUM_W        = 9;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_DATA_W   = 16;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 13'd2048;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 16'd2048;

    typedef enum logic [0:0] {
        CFG_IDX_WIDTH  = 1'b0,
        CFG_IDX_HEIGHT = 1'b1
    } t_cfg_idx;

    // Four 9-bit channel sums of one horizontal pair, red in the low bits.
    typedef struct packed {
        logic [SUM_W-1:0] alpha;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } t_pair;

    // Control of the request waiting between the front stage and the output stage.
    typedef struct packed {
        logic vld;
        logic frame_end;
    } t_s1_ctl;

endpackage

// File: design/rgba_box_downscale_2x2.sv
// Top level of the RGBA 2x2 box downscaler.
// A block's result goes through the pending request register, then the output register.
// Throughput: one pixel per cycle; input stalls only while a result waits on a stalled output.
// Reset clears counters, accumulator, pipeline valids and the size registers (2048 x 2048).
// The line store has no reset; each entry is written on an even row before it is read.
module rgba_box_downscale_2x2 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  rbd_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rbd_pkg::CH_W-1:0]            i_red_in,
    input  logic [rbd_pkg::CH_W-1:0]            i_green_in,
    input  logic [rbd_pkg::CH_W-1:0]            i_blue_in,
    input  logic [rbd_pkg::CH_W-1:0]            i_alpha_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rbd_pkg::CH_W-1:0]            o_red_out,
    output logic [rbd_pkg::CH_W-1:0]            o_green_out,
    output logic [rbd_pkg::CH_W-1:0]            o_blue_out,
    output logic [rbd_pkg::CH_W-1:0]            o_alpha_out,
    output logic                                o_frame_end
);
    import rbd_pkg::*;

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = $clog2(MAX_WIDTH) - 1;

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic                    cfg_wr;
    logic                    load_ok;
    t_s1_ctl                 s1_ctl;
    t_pair                   s1_pair;
    logic                    mem_we;
    logic                    mem_re;
    logic [AW-1:0]           mem_addr;
    t_pair                   mem_wdata;
    t_pair                   mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IDX_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    rbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .i_alpha     (i_alpha_in),
        .i_load_ok   (load_ok),
        .o_s1_ctl    (s1_ctl),
        .o_s1_pair   (s1_pair),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    rbd_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    rbd_avg_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_ctl    (s1_ctl),
        .i_s1_pair   (s1_pair),
        .i_above     (mem_rdata),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out),
        .o_alpha     (o_alpha_out),
        .o_frame_end (o_frame_end)
    );

    // A pixel is only held back while a finished block waits behind a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (s1_ctl.vld && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A store access is either a write on an even row or a read on an odd row, never both.
    a_store_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("line store written and read by the same request");

    // A waiting block that cannot move on must still be there next cycle.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_ctl.vld && !load_ok) |=> s1_ctl.vld)
        else $error("pending block lost while output stalled");

    // A line store read always turns into a pending block in the following cycle.
    a_read_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> s1_ctl.vld)
        else $error("line store read without a pending block");

endmodule

// File: design/rbd_line_store.sv
// Line store of pair sums: one write port, one registered read port.
module rbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  rbd_pkg::t_pair i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output rbd_pkg::t_pair o_rdata
);
    import rbd_pkg::*;

    t_pair r_mem [DEPTH];
    t_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read, so a waiting request keeps its operand.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rbd_front.sv
// Front stage: position counters, pair accumulation and line store access.
module rbd_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rbd_pkg::WIDTH_REG_W-1:0]     i_width,
    input  logic [rbd_pkg::HEIGHT_REG_W-1:0]    i_height,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rbd_pkg::CH_W-1:0]            i_red,
    input  logic [rbd_pkg::CH_W-1:0]            i_green,
    input  logic [rbd_pkg::CH_W-1:0]            i_blue,
    input  logic [rbd_pkg::CH_W-1:0]            i_alpha,
    input  logic                                i_load_ok,
    output rbd_pkg::t_s1_ctl                    o_s1_ctl,
    output rbd_pkg::t_pair                      o_s1_pair,
    output logic                                o_mem_we,
    output logic                                o_mem_re,
    output logic [$clog2(MAX_WIDTH)-2:0]        o_mem_addr,
    output rbd_pkg::t_pair                      o_mem_wdata
);
    import rbd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int SW = CW - 1;

    logic [CW-1:0]           r_col;
    logic [CW-1:0]           n_col;
    logic [HEIGHT_REG_W-1:0] r_row;
    logic [HEIGHT_REG_W-1:0] n_row;
    t_pair                   r_acc;
    t_pair                   r_s1_pair;
    t_s1_ctl                 r_s1_ctl;
    t_s1_ctl                 n_s1_ctl;

    logic [WW-1:0]           w_eff;
    logic [WW-1:0]           w_even;
    logic [CW-1:0]           w_last;
    logic [CW-1:0]           w_even_last;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic [HEIGHT_REG_W-1:0] h_even;
    logic [HEIGHT_REG_W-1:0] h_last;
    logic [HEIGHT_REG_W-1:0] h_even_last;
    logic                    accept;
    logic                    in_block;
    logic                    odd_col;
    logic                    odd_row;
    logic                    produce;
    t_pair                   px_pair;
    t_pair                   pair_sum;

    always_comb begin
        if (int'(i_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else if (i_width < WIDTH_REG_W'(2)) begin
            w_eff = WW'(2);
        end else begin
            w_eff = WW'(i_width);
        end
        h_eff       = (i_height < HEIGHT_REG_W'(2)) ? HEIGHT_REG_W'(2) : i_height;
        w_even      = {w_eff[WW-1:1], 1'b0};
        h_even      = {h_eff[HEIGHT_REG_W-1:1], 1'b0};
        w_last      = CW'(w_eff - WW'(1));
        w_even_last = CW'(w_even - WW'(1));
        h_last      = h_eff - HEIGHT_REG_W'(1);
        h_even_last = h_even - HEIGHT_REG_W'(1);
    end

    assign o_in_stall = r_s1_ctl.vld && !i_load_ok;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_block   = ({1'b0, r_col} < w_even) && (r_row < h_even);
    assign odd_col    = r_col[0];
    assign odd_row    = r_row[0];
    assign produce    = accept && in_block && odd_col && odd_row;

    always_comb begin
        px_pair.red   = {1'b0, i_red};
        px_pair.green = {1'b0, i_green};
        px_pair.blue  = {1'b0, i_blue};
        px_pair.alpha = {1'b0, i_alpha};
        pair_sum.red   = r_acc.red   + px_pair.red;
        pair_sum.green = r_acc.green + px_pair.green;
        pair_sum.blue  = r_acc.blue  + px_pair.blue;
        pair_sum.alpha = r_acc.alpha + px_pair.alpha;
    end

    // The last pixel of a row wraps the column; the last row wraps the frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (r_col >= w_last) begin
                n_col = '0;
                n_row = (r_row >= h_last) ? '0 : r_row + HEIGHT_REG_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_comb begin
        n_s1_ctl = r_s1_ctl;
        if (produce) begin
            n_s1_ctl.vld       = 1'b1;
            n_s1_ctl.frame_end = (r_col == w_even_last) && (r_row == h_even_last);
        end else if (i_load_ok) begin
            n_s1_ctl.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_acc    <= '0;
            r_s1_ctl <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1_ctl <= n_s1_ctl;
            if (accept && in_block && !odd_col) begin
                r_acc <= px_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_s1_pair <= pair_sum;
        end
    end

    assign o_mem_we    = accept && in_block && odd_col && !odd_row;
    assign o_mem_re    = produce;
    assign o_mem_addr  = r_col[CW-1:1];
    assign o_mem_wdata = pair_sum;
    assign o_s1_ctl    = r_s1_ctl;
    assign o_s1_pair   = r_s1_pair;

endmodule

// File: design/rbd_avg_out.sv
// Output stage: adds the stored pair to the current pair and holds the averaged pixel.
module rbd_avg_out (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rbd_pkg::t_s1_ctl         i_s1_ctl,
    input  rbd_pkg::t_pair           i_s1_pair,
    input  rbd_pkg::t_pair           i_above,
    output logic                     o_load_ok,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [rbd_pkg::CH_W-1:0] o_red,
    output logic [rbd_pkg::CH_W-1:0] o_green,
    output logic [rbd_pkg::CH_W-1:0] o_blue,
    output logic [rbd_pkg::CH_W-1:0] o_alpha,
    output logic                     o_frame_end
);
    import rbd_pkg::*;

    logic             r_out_vld;
    logic             r_frame_end;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;
    logic [CH_W-1:0]  r_alpha;
    logic             load;
    logic [SUM_W:0]   tot_red;
    logic [SUM_W:0]   tot_green;
    logic [SUM_W:0]   tot_blue;
    logic [SUM_W:0]   tot_alpha;

    assign o_load_ok = !r_out_vld || !i_out_stall;
    assign load      = i_s1_ctl.vld && o_load_ok;

    always_comb begin
        tot_red   = {1'b0, i_above.red}   + {1'b0, i_s1_pair.red};
        tot_green = {1'b0, i_above.green} + {1'b0, i_s1_pair.green};
        tot_blue  = {1'b0, i_above.blue}  + {1'b0, i_s1_pair.blue};
        tot_alpha = {1'b0, i_above.alpha} + {1'b0, i_s1_pair.alpha};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_load_ok) begin
            r_out_vld <= i_s1_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_red       <= tot_red[SUM_W:2];
            r_green     <= tot_green[SUM_W:2];
            r_blue      <= tot_blue[SUM_W:2];
            r_alpha     <= tot_alpha[SUM_W:2];
            r_frame_end <= i_s1_ctl.frame_end;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha     = r_alpha;
    assign o_frame_end = r_frame_end;

endmodule

// File: verif/tb_rgba_box_downscale_2x2.sv
// Self-checking testbench for the RGBA 2x2 box downscaler: size edge cases, a directed table and random frames.
`timescale 1ns / 100ps

module tb_rgba_box_downscale_2x2;
    import rbd_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int LAT_PAUSE   = 4;
    localparam int RAND_PIXELS = 285;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_px;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } t_result;

    typedef enum logic [0:0] {
        ROW_CFG = 1'b0,
        ROW_PIX = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [15:0] data;
        t_px         px;
        logic        typed;
        t_result     want;
    } t_dir_row;

    localparam t_px     PX_ZERO       = '0;
    localparam t_result RES_NONE      = '0;
    localparam t_result RES_WHITE_END = t_result'({32'hFFFFFFFF, 1'b1});
    localparam t_result RES_BLACK_END = t_result'({32'h00000000, 1'b1});

    // Pixel rows with want typed in carry their result; the others get the predictor's result.
    localparam t_dir_row DIR_TAB [31] = '{
        '{ROW_CFG, CFG_IDX_WIDTH,  16'd2, PX_ZERO, 1'b0, RES_NONE},
        '{ROW_CFG, CFG_IDX_HEIGHT, 16'd2, PX_ZERO, 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFFFFFFFF), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFFFFFFFF), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFFFFFFFF), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFFFFFFFF), 1'b1, RES_WHITE_END},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00000000), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00000000), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00000000), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00000000), 1'b1, RES_BLACK_END},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h0103FF80), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h0103FE81), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h01030082), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00020083), 1'b0, RES_NONE},
        '{ROW_CFG, CFG_IDX_WIDTH,  16'd3, PX_ZERO, 1'b0, RES_NONE},
        '{ROW_CFG, CFG_IDX_HEIGHT, 16'd3, PX_ZERO, 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h10203040), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hF0E0D0C0), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h55AA55AA), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h0F0F0F0F), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFFFEFDFC), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h12345678), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h9ABCDEF0), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h13579BDF), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h2468ACE0), 1'b0, RES_NONE},
        '{ROW_CFG, CFG_IDX_WIDTH,  16'd0, PX_ZERO, 1'b0, RES_NONE},
        '{ROW_CFG, CFG_IDX_HEIGHT, 16'd1, PX_ZERO, 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFF00FF00), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00FF00FF), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'hFF00FF00), 1'b0, RES_NONE},
        '{ROW_PIX, CFG_IDX_WIDTH,  16'd0, t_px'(32'h00FF00FF), 1'b0, RES_NONE}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_IDX_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [CH_W-1:0]       i_red_in    = '0;
    logic [CH_W-1:0]       i_green_in  = '0;
    logic [CH_W-1:0]       i_blue_in   = '0;
    logic [CH_W-1:0]       i_alpha_in  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CH_W-1:0]       o_red_out;
    logic [CH_W-1:0]       o_green_out;
    logic [CH_W-1:0]       o_blue_out;
    logic [CH_W-1:0]       o_alpha_out;
    logic                  o_frame_end;

    // Predictor state: size registers, position of the next pixel, pair sums.
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RST;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RST;
    logic [11:0]             col_next   = '0;
    logic [15:0]             row_next   = '0;
    t_pair                   pair_held  = '0;
    t_pair                   pair_line [MAX_W/2];

    t_result     averages_due [$];
    t_result     oldest;
    int unsigned pixels_sent   = 0;
    int unsigned regs_written  = 0;
    int unsigned results_seen  = 0;
    int unsigned frame_ends    = 0;
    int unsigned mismatches    = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_left     = 0;
    int unsigned calm_left     = 0;
    bit          pressure_go   = 1'b0;
    bit          pressure_done = 1'b0;

    rgba_box_downscale_2x2 #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_alpha_in  (i_alpha_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out),
        .o_frame_end (o_frame_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] quarter(input logic [8:0] upper, input logic [8:0] lower);
        logic [9:0] total;
        total = upper + lower;
        return total[9:2];
    endfunction

    // Advances the predictor by one pixel; returns 1 when the pixel completes a 2x2 block.
    function automatic bit box_average_step(input t_px px, output t_result res);
        int unsigned w;
        int unsigned h;
        int unsigned w_even;
        int unsigned h_even;
        t_pair       pair;
        t_pair       above;
        bit          made;
        made = 1'b0;
        res  = '0;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        h = (height_reg < 2) ? 2 : height_reg;
        w_even = w - (w % 2);
        h_even = h - (h % 2);
        if (col_next < w_even && row_next < h_even) begin
            if (!col_next[0]) begin
                pair_held.red   = {1'b0, px.red};
                pair_held.green = {1'b0, px.green};
                pair_held.blue  = {1'b0, px.blue};
                pair_held.alpha = {1'b0, px.alpha};
            end else begin
                pair.red   = pair_held.red   + {1'b0, px.red};
                pair.green = pair_held.green + {1'b0, px.green};
                pair.blue  = pair_held.blue  + {1'b0, px.blue};
                pair.alpha = pair_held.alpha + {1'b0, px.alpha};
                if (!row_next[0]) begin
                    pair_line[col_next >> 1] = pair;
                end else begin
                    above = pair_line[col_next >> 1];
                    res.red       = quarter(above.red, pair.red);
                    res.green     = quarter(above.green, pair.green);
                    res.blue      = quarter(above.blue, pair.blue);
                    res.alpha     = quarter(above.alpha, pair.alpha);
                    res.frame_end = (col_next == w_even - 1) && (row_next == h_even - 1);
                    made = 1'b1;
                end
            end
        end
        // A size lowered mid-frame can leave the position past the new end; that pixel
        // closes the row (and the frame) at once.
        if (col_next >= w - 1) begin
            col_next = '0;
            row_next = (row_next >= h - 1) ? 16'd0 : row_next + 16'd1;
        end else begin
            col_next = col_next + 12'd1;
        end
        return made;
    endfunction

    function automatic logic [7:0] rand_chan();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly back-to-back requests, some short gaps, a few long ones, and idle-free bursts.
    function automatic int unsigned pixel_gap();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input t_px px, input bit typed, input t_result want);
        int unsigned gap;
        t_result     res;
        bit          made;
        gap = pixel_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        i_alpha_in <= px.alpha;
        do @(posedge i_clk); while (o_in_stall);
        made = box_average_step(px, res);
        if (typed) res = want;
        if (made || typed) averages_due.push_back(res);
        pixels_sent++;
    endtask

    // Sends n random pixels, then, if asked, keeps going until the frame is complete.
    task automatic run_pixels(input int unsigned n, input bit pad);
        int unsigned i;
        t_px         px;
        i = 0;
        while (i < n || (pad && (col_next != 0 || row_next != 0))) begin
            px.red   = rand_chan();
            px.green = rand_chan();
            px.blue  = rand_chan();
            px.alpha = rand_chan();
            send_pixel(px, 1'b0, RES_NONE);
            i++;
        end
    endtask

    // Registers change only with no request in flight.
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        i_in_valid <= 1'b0;
        while (averages_due.size() != 0) @(posedge i_clk);
        repeat (LAT_PAUSE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
        else height_reg = data;
        regs_written++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (o_frame_end) frame_ends <= frame_ends + 1;
            if (averages_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t ns: expected no result, got %0d %0d %0d %0d end %0b",
                             $time, o_red_out, o_green_out, o_blue_out, o_alpha_out,
                             o_frame_end);
            end else begin
                oldest = averages_due.pop_front();
                check_field("red", oldest.red, o_red_out);
                check_field("green", oldest.green, o_green_out);
                check_field("blue", oldest.blue, o_blue_out);
                check_field("alpha", oldest.alpha, o_alpha_out);
                check_field("frame_end", {7'd0, oldest.frame_end}, {7'd0, o_frame_end});
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!pressure_done && pressure_go) begin
            // Hold the output side off long enough that requests back up into the input.
            i_out_stall   <= 1'b1;
            hold_left     <= 400;
            pressure_done <= 1'b1;
        end else if (calm_left != 0) begin
            i_out_stall <= 1'b0;
            calm_left   <= calm_left - 1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:9]: begin
                    i_out_stall <= 1'b0;
                    calm_left   <= $urandom_range(20, 80);
                end
                [10:36]: begin
                    i_out_stall <= 1'b1;
                    hold_left   <= $urandom_range(0, 3);
                end
                [37:39]: begin
                    i_out_stall <= 1'b1;
                    hold_left   <= $urandom_range(10, 40);
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    initial begin
        #40_000_000;
        $display("tb_rgba_box_downscale_2x2: done, errors");
        $finish;
    end

    initial begin
        int unsigned loop_start;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size: part of the first row.
        run_pixels(20, 1'b0);
        // Shrink mid-frame with the position already past the new last column.
        write_reg(CFG_IDX_WIDTH, 16'd4);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        run_pixels(0, 1'b1);

        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].kind == ROW_CFG) write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            else send_pixel(DIR_TAB[i].px, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // Width register beyond the line store; part of a row, then a narrower width ends it.
        write_reg(CFG_IDX_WIDTH, 16'hFFFF);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        run_pixels(24, 1'b0);
        write_reg(CFG_IDX_WIDTH, 16'd8);
        run_pixels(0, 1'b1);

        // Tallest frame, only a slice of it, then cut short by a height below range.
        // The output side is held off meanwhile so that the input backs up.
        write_reg(CFG_IDX_WIDTH, 16'd2);
        write_reg(CFG_IDX_HEIGHT, 16'hFFFF);
        pressure_go = 1'b1;
        run_pixels(80, 1'b0);
        write_reg(CFG_IDX_HEIGHT, 16'd0);
        run_pixels(0, 1'b1);

        loop_start = pixels_sent;
        while (pixels_sent - loop_start < RAND_PIXELS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(2, 12);
            h = $urandom_range(2, 6);
            n = w * h * $urandom_range(1, 2);
            // The last frame is cut to what is left; padding still completes it.
            if (n > RAND_PIXELS - (pixels_sent - loop_start))
                n = RAND_PIXELS - (pixels_sent - loop_start);
            write_reg(CFG_IDX_WIDTH, w[15:0]);
            write_reg(CFG_IDX_HEIGHT, h[15:0]);
            run_pixels(n, 1'b1);
        end

        i_in_valid <= 1'b0;
        while (averages_due.size() != 0) @(posedge i_clk);
        repeat (2 * LAT_PAUSE) @(posedge i_clk);

        $display("Run covered %0d pixels under %0d register writes, sizes from 2x2 up to",
                 pixels_sent, regs_written);
        $display("a clamped 4096 width and 65535 rows; %0d averaged pixels checked, %0d ends.",
                 results_seen, frame_ends);
        if (mismatches == 0)
            $display("tb_rgba_box_downscale_2x2: done, clean");
        else
            $display("tb_rgba_box_downscale_2x2: done, errors");
        $finish;
    end

endmodule
